>>> rtl/zero_compress_bitmap_defines.svh
// Assertion macros for the zero compression bitmap block
`ifndef ZERO_COMPRESS_BITMAP_DEFINES_SVH
`define ZERO_COMPRESS_BITMAP_DEFINES_SVH

`ifndef SYNTHESIS
`define ZCB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ZCB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ZCB_ASSERT_CLK(lbl, prop, msg)
`define ZCB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/zcb_pkg.sv
// Types and constants shared by the zero compression bitmap block
package zcb_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_TAG  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  localparam logic CFG_ELEM_MODE = 1'b0;
  localparam logic CFG_DST_CAP   = 1'b1;

  localparam logic [6:0] BLK_ELEMS16 = 7'd64;
  localparam logic [6:0] BLK_ELEMS32 = 7'd32;
  localparam logic [2:0] TAG_ELEMS16 = 3'd4;
  localparam logic [2:0] TAG_ELEMS32 = 3'd1;
  localparam logic [63:0] TAG_MASK32 = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    kind_t        kind;
    logic [30:0]  offset;
    logic [63:0]  value;
    logic [31:0]  bytes;
  } result_t;

  typedef struct packed {
    logic [2:0]         vld;
    result_t [2:0]      res;
  } result_set_t;

endpackage

>>> rtl/zcb_core.sv
// Per-word compression step: block state, capacity checks and result set
module zcb_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [31:0]         elem_value,
  input  logic                last_elem,
  input  logic                elem_mode,
  input  logic [31:0]         dst_capacity_bytes,
  output zcb_pkg::result_set_t rs
);
  import zcb_pkg::*;

  logic [63:0] tag_r, tag_nxt;
  logic [30:0] slot_r, slot_nxt;
  logic [31:0] next_r, next_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        err_r, err_nxt;

  logic [31:0] v, cap, next_a, next_b, slot_a;
  logic [2:0]  tsize;
  logic [6:0]  bsize, pos_inc;
  logic [63:0] tmask, tag_a, tag_b, tag_out;
  logic        nz, opened, err1, err2, err, close;

  always_comb begin
    v       = elem_mode ? elem_value : {16'd0, elem_value[15:0]};
    nz      = (v != 32'd0);
    cap     = elem_mode ? {2'd0, dst_capacity_bytes[31:2]} : {1'b0, dst_capacity_bytes[31:1]};
    tsize   = elem_mode ? TAG_ELEMS32 : TAG_ELEMS16;
    bsize   = elem_mode ? BLK_ELEMS32 : BLK_ELEMS16;
    tmask   = elem_mode ? TAG_MASK32 : '1;
    opened  = (pos_r == 6'd0);
    err1    = opened && (({1'b0, next_r} + {30'd0, tsize}) > {1'b0, cap});
    next_a  = opened ? (next_r + {29'd0, tsize}) : next_r;
    slot_a  = opened ? next_r : {1'b0, slot_r};
    tag_a   = opened ? 64'd0 : tag_r;
    err2    = nz && (next_a >= cap);
    err     = err1 || err2;
    next_b  = next_a + {31'd0, nz};
    tag_b   = (tag_a | (nz ? (64'd1 << pos_r) : 64'd0)) & tmask;
    pos_inc = {1'b0, pos_r} + 7'd1;
    close   = (pos_inc >= bsize) || last_elem;
    tag_out = tag_b;
    if (pos_inc < bsize) begin
      tag_out = tag_b | ({64{1'b1}} << pos_inc[5:0]);
    end
    tag_out = tag_out & tmask;

    rs = '0;
    rs.res[0].kind   = KIND_DATA;
    rs.res[0].offset = next_a[30:0];
    rs.res[0].value  = {32'd0, v};
    rs.res[1].kind   = KIND_TAG;
    rs.res[1].offset = slot_a[30:0];
    rs.res[1].value  = tag_out;
    rs.res[2].kind   = KIND_DONE;
    rs.res[2].bytes  = elem_mode ? {next_b[29:0], 2'd0} : {next_b[30:0], 1'b0};
    if (err_r) begin
      rs.vld = 3'b000;
    end else if (err) begin
      rs.vld           = 3'b001;
      rs.res[0].kind   = KIND_ERR;
      rs.res[0].offset = '0;
      rs.res[0].value  = '0;
    end else begin
      rs.vld = {last_elem, close, nz};
    end

    tag_nxt  = tag_r;
    slot_nxt = slot_r;
    next_nxt = next_r;
    pos_nxt  = pos_r;
    err_nxt  = err_r;
    if (fire) begin
      if (last_elem) begin
        tag_nxt  = '0;
        slot_nxt = '0;
        next_nxt = '0;
        pos_nxt  = '0;
        err_nxt  = 1'b0;
      end else if (!err_r) begin
        if (err) begin
          err_nxt = 1'b1;
        end else begin
          tag_nxt  = close ? 64'd0 : tag_b;
          pos_nxt  = close ? 6'd0 : pos_inc[5:0];
          next_nxt = next_b;
          slot_nxt = slot_a[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      slot_r <= '0;
      next_r <= '0;
      pos_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      tag_r  <= tag_nxt;
      slot_r <= slot_nxt;
      next_r <= next_nxt;
      pos_r  <= pos_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

>>> rtl/zcb_out.sv
// Result buffer: hold up to three results of one word and send them in order
module zcb_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  zcb_pkg::result_set_t rs,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_tlast,
  output logic [1:0]           out_tuser,
  output logic [127:0]         out_tdata
);
  import zcb_pkg::*;

  logic [2:0]    vld_r, vld_nxt;
  result_t [2:0] res_r, res_nxt;
  result_t       cur;
  logic [2:0]    low;
  logic          pop;

  always_comb begin
    low = vld_r[0] ? 3'b001 : (vld_r[1] ? 3'b010 : (vld_r[2] ? 3'b100 : 3'b000));
    cur = vld_r[0] ? res_r[0] : (vld_r[1] ? res_r[1] : res_r[2]);
    out_tvalid = |vld_r;
    out_tlast  = $onehot(vld_r);
    out_tuser  = cur.kind;
    out_tdata  = {1'b0, cur.bytes, cur.value, cur.offset};
    pop        = out_tvalid && out_tready;
    free       = (vld_r == 3'b000) || (out_tlast && out_tready);
    vld_nxt    = pop ? (vld_r & ~low) : vld_r;
    res_nxt    = res_r;
    if (load) begin
      vld_nxt = rs.vld;
      res_nxt = rs.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 3'b000;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

>>> rtl/zero_compress_bitmap.sv
// Top level of the zero compression bitmap block
// Takes one 32-bit element per word and writes the compressed stream as data, tag, done
// and error words. A word is taken every cycle while each element gives at most one
// result and the output is not stalled; the result buffer sends one result a cycle while
// the receiver is ready, so an element that gives several results (up to 3: data, tag,
// done) holds the input until its last result is taken. The element passes the input
// register, then the result buffer, before its first result is valid. tlast on the output
// marks the last result of an element; tuser carries the result kind.
`include "zero_compress_bitmap_defines.svh"

module zero_compress_bitmap (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] elem_value
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [30:0] write_offset, [94:31] write_value,
                                   // [126:95] out_bytes, [127] zero
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  output logic         out_tlast
);
  import zcb_pkg::*;

  logic        mode_r;
  logic [31:0] cap_r;
  logic        in_vld_r, in_vld_nxt;
  logic [31:0] in_val_r;
  logic        in_last_r;
  logic        fire, free;
  result_set_t rs;

  assign cfg_ready  = 1'b1;
  assign fire       = in_vld_r && free;
  assign in_tready  = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cap_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ELEM_MODE: mode_r <= cfg_data[0];
        CFG_DST_CAP:   cap_r  <= cfg_data;
        default:       mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_val_r  <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  zcb_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .elem_value         (in_val_r),
    .last_elem          (in_last_r),
    .elem_mode          (mode_r),
    .dst_capacity_bytes (cap_r),
    .rs                 (rs)
  );

  zcb_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .rs         (rs),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  `ZCB_ASSERT_CLK(a_more_follows, (out_tvalid && out_tready && !out_tlast) |=> out_tvalid, "result missing after non-last result")
  `ZCB_ASSERT_NEVER(a_err_alone, out_tvalid && (out_tuser == KIND_ERR) && !out_tlast, "error result not last of its word")
  `ZCB_ASSERT_NEVER(a_done_last, out_tvalid && (out_tuser == KIND_DONE) && !out_tlast, "done result not last of its word")
  `ZCB_ASSERT_NEVER(a_no_take_busy, fire && out_tvalid && !out_tlast, "word loaded over pending results")

endmodule

>>> sim/testbench.sv
// Testbench for zero_compress_bitmap: directed and random element streams checked by a predictor
`timescale 1ns / 100ps

module testbench;
  import zcb_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 110;

  typedef struct {
    kind_t        kind;
    logic [30:0]  offset;
    logic [63:0]  value;
    logic [31:0]  nbytes;
    logic         fin;
  } dst_write_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;   // [31:0] elem_value
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // [30:0] write_offset, [94:31] write_value,
                            // [126:95] out_bytes, [127] zero
  logic [1:0]   out_tuser;  // [1:0] result_kind
  logic         out_tlast;

  // predictor state and its copy of the registers
  logic         mode_wide;
  logic [31:0]  cap_bytes;
  logic [63:0]  blk_tag;
  logic [31:0]  blk_slot;
  logic [31:0]  dst_next;
  int           blk_pos;
  logic         run_failed;

  dst_write_t   pending_writes[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           random_sent = 0;

  logic         rx_hold = 1'b0;
  int           rx_mode = 0;
  int           rx_left = 0;
  logic [6:0]   rx_pat = 7'b1011001;
  event         stall_kick;

  zero_compress_bitmap dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_run();
    blk_tag    = '0;
    blk_slot   = '0;
    dst_next   = '0;
    blk_pos    = 0;
    run_failed = 1'b0;
  endfunction

  function automatic void push_write(kind_t kind, logic [30:0] off, logic [63:0] val,
                                     logic [31:0] nbytes);
    dst_write_t w;
    w.kind   = kind;
    w.offset = off;
    w.value  = val;
    w.nbytes = nbytes;
    w.fin    = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function automatic void refuse(logic fin);
    push_write(KIND_ERR, '0, '0, '0);
    pending_writes[pending_writes.size() - 1].fin = 1'b1;
    if (fin) begin
      clear_run();
    end else begin
      run_failed = 1'b1;
    end
  endfunction

  function automatic void compress_elem(logic [31:0] din, logic fin);
    logic [2:0]  esize;
    int          bsize;
    logic [32:0] tsize;
    logic [32:0] cap;
    logic [63:0] tmask;
    logic [63:0] val;
    logic [63:0] tag_out;
    int          n;
    esize = mode_wide ? 3'd4 : 3'd2;
    bsize = mode_wide ? 32 : 64;
    tsize = mode_wide ? 33'd1 : 33'd4;
    tmask = mode_wide ? 64'h0000_0000_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
    cap   = mode_wide ? {3'b0, cap_bytes[31:2]} : {2'b0, cap_bytes[31:1]};
    val   = mode_wide ? {32'h0, din} : {48'h0, din[15:0]};
    n     = 0;
    if (run_failed) begin
      if (fin) clear_run();
      return;
    end
    if (blk_pos == 0) begin
      if ({1'b0, dst_next} + tsize > cap) begin
        refuse(fin);
        return;
      end
      blk_slot = dst_next;
      dst_next = dst_next + tsize[31:0];
      blk_tag  = '0;
    end
    if (val != 0) begin
      if ({1'b0, dst_next} >= cap) begin
        refuse(fin);
        return;
      end
      push_write(KIND_DATA, dst_next[30:0], val, '0);
      n++;
      dst_next = dst_next + 32'd1;
      blk_tag  = blk_tag | ((64'd1 << blk_pos) & tmask);
    end
    blk_pos++;
    if (blk_pos >= bsize || fin) begin
      tag_out = blk_tag;
      if (blk_pos < bsize) tag_out = tag_out | (64'hFFFF_FFFF_FFFF_FFFF << blk_pos);
      push_write(KIND_TAG, blk_slot[30:0], tag_out & tmask, '0);
      n++;
      blk_tag = '0;
      blk_pos = 0;
    end
    if (fin) begin
      push_write(KIND_DONE, '0, '0, dst_next * esize);
      n++;
      clear_run();
    end
    if (n > 0) pending_writes[pending_writes.size() - 1].fin = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    dst_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d off %h val %h bytes %h last %b", out_tuser,
                   out_tdata[30:0], out_tdata[94:31], out_tdata[126:95], out_tlast);
      end else begin
        want = pending_writes.pop_front();
        if (out_tuser !== want.kind || out_tdata[30:0] !== want.offset ||
            out_tdata[94:31] !== want.value || out_tdata[126:95] !== want.nbytes ||
            out_tdata[127] !== 1'b0 || out_tlast !== want.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch (exp/got): kind %0d/%0d off %h/%h val %h/%h bytes %h/%h last %b/%b",
                     want.kind, out_tuser, want.offset, out_tdata[30:0], want.value,
                     out_tdata[94:31], want.nbytes, out_tdata[126:95], want.fin, out_tlast);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_pat <= {rx_pat[5:0], rx_pat[6]};
    case (rx_mode)
      0: begin
        out_tready <= !rx_hold;
      end
      1: begin
        out_tready <= !rx_hold && ($urandom_range(0, 9) < 6);
      end
      default: begin
        out_tready <= !rx_hold && rx_pat[0];
      end
    endcase
  end

  initial begin : rx_pressure
    forever begin
      @(stall_kick);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("zero_compress_bitmap test failed");
      $finish;
    end
  end

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic mode, logic [31:0] cap);
    logic [31:0] junk;
    settle();
    junk = $urandom();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ELEM_MODE;
    cfg_data  <= {junk[31:1], mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_wide = mode;
    cfg_index <= CFG_DST_CAP;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_bytes = cap;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_elem(logic [31:0] v, logic fin);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    compress_elem(v, fin);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_elem(int zero_pct);
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 99) < zero_pct) return '0;
    case ($urandom_range(0, 3))
      0: return r;
      1: return {r[31:16], 16'h0};
      2: return 32'hFFFF_FFFF;
      default: return {16'h0, r[15:0]};
    endcase
  endfunction

  task automatic send_stream(int len, int zero_pct, logic close);
    for (int i = 0; i < len; i++) begin
      send_elem(pick_elem(zero_pct), close && (i == len - 1));
      random_sent++;
    end
  endtask

  task automatic test_reserve_check();
    send_elem(32'h0, 1'b1);
    configure(1'b0, 32'd6);
    send_elem(32'h5, 1'b1);
    configure(1'b0, 32'd8);
    send_elem(32'h0, 1'b0);
    send_elem(32'hFFFF_0000, 1'b0);
    send_elem(32'h0, 1'b1);
  endtask

  task automatic test_extremes_16();
    configure(1'b0, 32'hFFFF_FFFF);
    send_elem(32'h0, 1'b0);
    send_elem(32'hFFFF_FFFF, 1'b0);
    send_elem(32'hFFFF_0000, 1'b0);
    send_elem(32'h1, 1'b0);
    send_elem(32'h8000, 1'b1);
  endtask

  task automatic test_extremes_32();
    configure(1'b1, 32'd64);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h0, 1'b0);
    send_elem(32'hFFFF_FFFF, 1'b0);
    send_elem(32'h1, 1'b1);
  endtask

  task automatic test_dst_short();
    configure(1'b0, 32'd12);
    send_elem(32'h1, 1'b0);
    send_elem(32'h2, 1'b0);
    send_elem(32'h3, 1'b0);
    send_elem(32'h0, 1'b0);
    send_elem(32'h7, 1'b1);
    send_elem(32'h9, 1'b1);
    send_elem(32'h1, 1'b0);
    send_elem(32'h2, 1'b0);
    send_elem(32'h3, 1'b1);
    send_elem(32'h0, 1'b1);
  endtask

  task automatic test_backpressure();
    configure(1'b0, 32'hFFFF_FFFF);
    -> stall_kick;
    for (int i = 0; i < 48; i++)
      send_elem($urandom() | 32'h1, i == 47);
  endtask

  task automatic test_random_streams();
    int          pick;
    int          streams;
    int          len;
    logic [31:0] cap;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: cap = 32'h0;
        1: cap = 32'hFFFF_FFFF;
        2, 3: cap = $urandom_range(8, 200);
        default: cap = $urandom_range(1000, 100000);
      endcase
      configure($urandom_range(0, 1), cap);
      streams = $urandom_range(1, 4);
      for (int s = 0; s < streams && random_sent < RANDOM_ITEMS; s++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 40);
        if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
        send_stream(len, $urandom_range(20, 70),
                    (s != streams - 1) || ($urandom_range(0, 3) != 0));
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_ELEM_MODE;
    cfg_data   <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    mode_wide  = 1'b0;
    cap_bytes  = '0;
    clear_run();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reserve_check();
    test_extremes_16();
    test_extremes_32();
    test_dst_short();
    test_backpressure();
    test_random_streams();
    settle();
    if (mismatches == 0) begin
      $display("zero_compress_bitmap test passed");
    end else begin
      $display("zero_compress_bitmap test failed");
    end
    $finish;
  end

endmodule
